>>> design/mt_pkg.sv
// Package for the MT19937 random generator: widths, tempering and twist
// constants, memory port structs, fill state enum and result item type.
// No dependencies; every other design file imports it.
package mt_pkg;

   // Table geometry
   localparam int STATE_WORDS   = 624;
   localparam int MIDDLE_OFFSET = 397;
   localparam int INDEX_WIDTH   = $clog2(STATE_WORDS);

   // Payload widths
   localparam int WORD_WIDTH    = 32;
   localparam int RANGE_WIDTH   = 31;
   localparam int PRODUCT_WIDTH = WORD_WIDTH + RANGE_WIDTH;

   // Output queue and pipeline occupancy
   localparam int FIFO_DEPTH        = 4;
   localparam int FIFO_PTR_WIDTH    = $clog2(FIFO_DEPTH);
   localparam int FIFO_COUNT_WIDTH  = FIFO_PTR_WIDTH + 1;
   localparam int PIPE_COUNT_WIDTH  = 2;

   // Configuration port
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic [CSR_ADDR_WIDTH-1:0] SEED_ADDR = '0;

   // Generator constants
   localparam logic [WORD_WIDTH-1:0] DEFAULT_SEED = 32'd5489;
   localparam logic [WORD_WIDTH-1:0] INIT_MULT    = 32'd1812433253;
   localparam logic [WORD_WIDTH-1:0] TWIST_XOR    = 32'h9908b0df;
   localparam logic [WORD_WIDTH-1:0] TEMPER_B     = 32'h9d2c5680;
   localparam logic [WORD_WIDTH-1:0] TEMPER_C     = 32'hefc60000;

   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [WORD_WIDTH-1:0]  word_type;

   localparam index_type LAST_INDEX = index_type'(STATE_WORDS - 1);

   // Table write port
   typedef struct packed {
      logic      en;
      index_type addr;
      word_type  data;
   } mem_wr_type;

   // Table read ports: the following word and the middle-offset word
   typedef struct packed {
      logic      en;
      index_type addr_nxt;
      index_type addr_mid;
   } mem_rd_type;

   // One result transaction
   typedef struct packed {
      word_type               word;
      logic [RANGE_WIDTH-1:0] scaled;
   } rsp_item_type;

   // Seeding sequencer states
   typedef enum logic [1:0] {
      FILL_SEED,
      FILL_MUL,
      FILL_ADD,
      FILL_RUN
   } fill_state_type;

   // Sequencer status toward the twist pipeline and the top level
   typedef struct packed {
      logic busy;
      logic restart;
   } fill_status_type;

endpackage

>>> design/mt_if.sv
// Request and response channel interfaces of the MT19937 generator.
// Depends on mt_pkg for payload widths.
interface mt_req_if;
   import mt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [RANGE_WIDTH-1:0] range;

   modport source (output valid, output range, input ready);
   modport sink   (input valid, input range, output ready);
endinterface

interface mt_rsp_if;
   import mt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [WORD_WIDTH-1:0]  word;
   logic [RANGE_WIDTH-1:0] scaled;

   modport source (output valid, output word, output scaled, input ready);
   modport sink   (input valid, input word, input scaled, output ready);
endinterface

>>> design/mt19937_random_generator.sv
// MT19937 random generator, top level.
// Channels: req_chan carries range (31 bits); rsp_chan returns word, the next
// tempered 32-bit output, and scaled = (word * range) >> 32 (0 for range 0).
// A transaction moves at a clock edge with valid and ready both high.
// Throughput: one transaction per cycle while ready is high. The 624 x 32
// table has two read ports and one write port; each transaction reads the
// following word and the middle-offset word and writes back its own twisted
// word, so the twist runs in place, one word per transaction.
// Path of a request: the table read, the twist and temper, and the scaling
// multiply, each registered, before the response is presented on rsp_chan.
// Reset and seed writes: the table refills from the seed (5489 after reset),
// each word in a multiply state and an add state; req_chan ready stays low
// meanwhile. Write the seed at byte address 0 only while idle.
// Stalls: finished transactions wait in a four-entry queue; ready drops
// once the queue and the pipeline together hold four transactions.
// Depends on mt_pkg, mt_if and the mt_* submodules.
module mt19937_random_generator (
   input  logic                               clock,
   input  logic                               reset,
   mt_req_if.sink                             req_chan,
   mt_rsp_if.source                           rsp_chan,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mt_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [mt_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [mt_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                               pready
);
   import mt_pkg::*;

   word_type                     seed_ff, seed_in;
   logic                         seed_write;
   fill_status_type              fill;
   mem_wr_type                   fill_wr;
   mem_wr_type                   twist_wr;
   mem_wr_type                   table_wr;
   mem_rd_type                   table_rd;
   word_type                     rdata_nxt;
   word_type                     rdata_mid;
   logic                         accept;
   logic                         push;
   rsp_item_type                 push_item;
   logic [PIPE_COUNT_WIDTH-1:0]  occupancy;
   logic [FIFO_COUNT_WIDTH-1:0]  fifo_count;
   logic [FIFO_COUNT_WIDTH-1:0]  in_flight;

   // Configuration port: seed register
   always_comb begin
      pready     = 1'b1;
      seed_write = psel && penable && pwrite && (paddr == SEED_ADDR);
      seed_in    = seed_write ? pwdata : seed_ff;
      prdata     = (paddr == SEED_ADDR) ? seed_ff : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= DEFAULT_SEED;
      end else begin
         seed_ff <= seed_in;
      end
   end

   // Accept requests while not filling and the queue has room
   always_comb begin
      in_flight      = FIFO_COUNT_WIDTH'(occupancy) + fifo_count;
      req_chan.ready = !fill.busy && (in_flight < FIFO_COUNT_WIDTH'(FIFO_DEPTH));
      accept         = req_chan.valid && req_chan.ready;
      table_wr       = fill.busy ? fill_wr : twist_wr;
   end

   mt_seed_fill u_fill (
      .clock  (clock),
      .reset  (reset),
      .start  (seed_write),
      .seed   (seed_ff),
      .wr     (fill_wr),
      .status (fill)
   );

   mt_table_ram u_table (
      .clock     (clock),
      .wr        (table_wr),
      .rd        (table_rd),
      .rdata_nxt (rdata_nxt),
      .rdata_mid (rdata_mid)
   );

   mt_twist_pipe u_twist (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .range_in  (req_chan.range),
      .fill      (fill),
      .seed      (seed_ff),
      .rdata_nxt (rdata_nxt),
      .rdata_mid (rdata_mid),
      .rd        (table_rd),
      .wr        (twist_wr),
      .push      (push),
      .push_item (push_item),
      .occupancy (occupancy)
   );

   mt_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .count     (fifo_count),
      .rsp       (rsp_chan)
   );

endmodule

>>> design/mt_table_ram.sv
// State table memory: 624 x 32, one write port, two registered read ports.
// Depends on mt_pkg for the port structs.
module mt_table_ram (
   input  logic               clock,
   input  mt_pkg::mem_wr_type wr,
   input  mt_pkg::mem_rd_type rd,
   output mt_pkg::word_type   rdata_nxt,
   output mt_pkg::word_type   rdata_mid
);
   import mt_pkg::*;

   word_type mem [STATE_WORDS];
   word_type rdata_nxt_ff;
   word_type rdata_mid_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // Read ports, registered
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata_nxt_ff <= mem[rd.addr_nxt];
         rdata_mid_ff <= mem[rd.addr_mid];
      end
   end

   assign rdata_nxt = rdata_nxt_ff;
   assign rdata_mid = rdata_mid_ff;

endmodule

>>> design/mt_seed_fill.sv
// Seeding sequencer: fills the state table from the seed with the
// multiplier recurrence, each word in a multiply and an add state. Depends on mt_pkg.
module mt_seed_fill (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  mt_pkg::word_type        seed,
   output mt_pkg::mem_wr_type      wr,
   output mt_pkg::fill_status_type status
);
   import mt_pkg::*;

   fill_state_type state_ff, state_in;
   index_type      idx_ff, idx_in;
   word_type       prev_ff, prev_in;
   word_type       prod_ff, prod_in;
   word_type       mixed;
   word_type       sum;

   // State and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FILL_SEED;
      end else begin
         state_ff <= state_in;
      end
      idx_ff  <= idx_in;
      prev_ff <= prev_in;
      prod_ff <= prod_in;
   end

   // Next state, table writes and status
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      prev_in        = prev_ff;
      mixed          = prev_ff ^ (prev_ff >> 30);
      prod_in        = prod_ff;
      sum            = prod_ff + WORD_WIDTH'(idx_ff);
      wr             = '0;
      status.busy    = 1'b1;
      status.restart = 1'b0;
      unique case (state_ff)
         FILL_SEED: begin
            // Entry zero is the seed itself
            wr             = '{en: 1'b1, addr: '0, data: seed};
            prev_in        = seed;
            idx_in         = index_type'(1);
            status.restart = 1'b1;
            state_in       = FILL_MUL;
         end
         FILL_MUL: begin
            prod_in  = INIT_MULT * mixed;
            state_in = FILL_ADD;
         end
         FILL_ADD: begin
            wr      = '{en: 1'b1, addr: idx_ff, data: sum};
            prev_in = sum;
            if (idx_ff == LAST_INDEX) begin
               state_in = FILL_RUN;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = FILL_MUL;
            end
         end
         FILL_RUN: begin
            status.busy = 1'b0;
         end
         default: begin
            state_in = FILL_SEED;
         end
      endcase
      // A seed write restarts the fill
      if (start) begin
         state_in = FILL_SEED;
      end
   end

endmodule

>>> design/mt_twist_pipe.sv
// Twist, temper and scale pipeline: twists one table word per transaction
// in place, tempers it and forms (word * range) >> 32. Depends on mt_pkg.
module mt_twist_pipe (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic [mt_pkg::RANGE_WIDTH-1:0]        range_in,
   input  mt_pkg::fill_status_type               fill,
   input  mt_pkg::word_type                      seed,
   input  mt_pkg::word_type                      rdata_nxt,
   input  mt_pkg::word_type                      rdata_mid,
   output mt_pkg::mem_rd_type                    rd,
   output mt_pkg::mem_wr_type                    wr,
   output logic                                  push,
   output mt_pkg::rsp_item_type                  push_item,
   output logic [mt_pkg::PIPE_COUNT_WIDTH-1:0]   occupancy
);
   import mt_pkg::*;

   localparam index_type MID_WRAP = index_type'(STATE_WORDS - MIDDLE_OFFSET);
   localparam index_type MID_STEP = index_type'(MIDDLE_OFFSET);

   index_type              idx_ff, idx_in;
   word_type               cur_ff, cur_in;
   logic                   b_valid_ff;
   index_type              b_idx_ff;
   logic [RANGE_WIDTH-1:0] b_range_ff;
   logic                   c_valid_ff;
   word_type               c_word_ff;
   logic [RANGE_WIDTH-1:0] c_range_ff;

   index_type                idx_nxt;
   index_type                idx_mid;
   word_type                 mixed;
   word_type                 twisted;
   logic [PRODUCT_WIDTH-1:0] product;

   function automatic word_type temper(input word_type value);
      word_type y;
      y = value;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // Read addresses for the word after this one and the middle-offset word
   always_comb begin
      idx_nxt = (idx_ff == LAST_INDEX) ? '0 : idx_ff + 1'b1;
      idx_mid = (idx_ff >= MID_WRAP) ? idx_ff - MID_WRAP : idx_ff + MID_STEP;
      rd      = '{en: accept, addr_nxt: idx_nxt, addr_mid: idx_mid};
   end

   // Twist the current word; cur_ff holds its value from the last pass
   always_comb begin
      mixed   = {cur_ff[WORD_WIDTH-1], rdata_nxt[WORD_WIDTH-2:0]};
      twisted = rdata_mid ^ (mixed >> 1) ^ (mixed[0] ? TWIST_XOR : '0);
      wr      = '{en: b_valid_ff, addr: b_idx_ff, data: twisted};
   end

   // Advance the index and carry the following word forward
   always_comb begin
      idx_in = idx_ff;
      cur_in = cur_ff;
      if (fill.restart) begin
         idx_in = '0;
         cur_in = seed;
      end else begin
         if (accept) begin
            idx_in = idx_nxt;
         end
         if (b_valid_ff) begin
            cur_in = rdata_nxt;
         end
      end
   end

   // Pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         idx_ff     <= idx_in;
         b_valid_ff <= accept;
         c_valid_ff <= b_valid_ff;
      end
      cur_ff     <= cur_in;
      b_idx_ff   <= idx_ff;
      b_range_ff <= range_in;
      c_word_ff  <= temper(twisted);
      c_range_ff <= b_range_ff;
   end

   // Scale: keep the high bits of word * range
   always_comb begin
      product   = PRODUCT_WIDTH'(c_word_ff) * PRODUCT_WIDTH'(c_range_ff);
      push      = c_valid_ff;
      push_item = '{word: c_word_ff, scaled: product[PRODUCT_WIDTH-1:WORD_WIDTH]};
      occupancy = PIPE_COUNT_WIDTH'(b_valid_ff) + PIPE_COUNT_WIDTH'(c_valid_ff);
   end

endmodule

>>> design/mt_out_fifo.sv
// Output queue: holds finished transactions while the receiver stalls and
// drives the response channel. Depends on mt_pkg and mt_if.
module mt_out_fifo (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   input  mt_pkg::rsp_item_type                 push_item,
   output logic [mt_pkg::FIFO_COUNT_WIDTH-1:0]  count,
   mt_rsp_if.source                             rsp
);
   import mt_pkg::*;

   rsp_item_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_COUNT_WIDTH-1:0] count_ff, count_in;
   logic                        pop;
   rsp_item_type                head;

   // Pointer and count update
   always_comb begin
      pop       = rsp.valid && rsp.ready;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + FIFO_COUNT_WIDTH'(push) - FIFO_COUNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Present the head transaction
   always_comb begin
      head       = entry_ff[rd_ptr_ff];
      rsp.valid  = (count_ff != '0);
      rsp.word   = head.word;
      rsp.scaled = head.scaled;
      count      = count_ff;
   end

endmodule

>>> tb/mt_draw_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the MT19937 generator: watches the request, response and
// seed-write traffic, predicts each draw and compares it field by field.
// Depends on mt_pkg for widths, constants and the response item type.
module mt_draw_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [mt_pkg::RANGE_WIDTH-1:0]    req_range,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [mt_pkg::WORD_WIDTH-1:0]     rsp_word,
   input  logic [mt_pkg::RANGE_WIDTH-1:0]    rsp_scaled,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [mt_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [mt_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output int                                draws_pending,
   output int                                error_count
);
   import mt_pkg::*;

   localparam word_type TOP_BIT_SEL  = 32'h8000_0000;
   localparam word_type LOW_BITS_SEL = 32'h7fff_ffff;

   // Predicted generator state
   word_type     state_words [STATE_WORDS];
   int unsigned  next_pos;
   rsp_item_type expected_draws [$];
   rsp_item_type oldest;
   rsp_item_type predicted;

   // Refill the table from a seed; the next draw twists first
   task automatic seed_table(input word_type seed_value);
      word_type prev;
      state_words[0] = seed_value;
      for (int i = 1; i < STATE_WORDS; i++) begin
         prev = state_words[i-1];
         state_words[i] = INIT_MULT * (prev ^ (prev >> 30)) + word_type'(i);
      end
      next_pos = STATE_WORDS;
   endtask

   // Regenerate all table words in place
   task automatic twist_table;
      word_type mixed;
      word_type fresh;
      for (int k = 0; k < STATE_WORDS; k++) begin
         mixed = (state_words[k] & TOP_BIT_SEL)
               | (state_words[(k + 1) % STATE_WORDS] & LOW_BITS_SEL);
         fresh = state_words[(k + MIDDLE_OFFSET) % STATE_WORDS] ^ (mixed >> 1);
         if (mixed[0])
            fresh = fresh ^ TWIST_XOR;
         state_words[k] = fresh;
      end
      next_pos = 0;
   endtask

   function automatic word_type temper_word(input word_type raw);
      word_type y;
      y = raw;
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction

   // Produce the next word and its scaled form, advancing the state
   task automatic predict_draw(input logic [RANGE_WIDTH-1:0] bound,
                               output rsp_item_type item);
      logic [PRODUCT_WIDTH-1:0] product;
      if (next_pos >= STATE_WORDS)
         twist_table();
      item.word = temper_word(state_words[next_pos]);
      next_pos++;
      product = PRODUCT_WIDTH'(item.word) * PRODUCT_WIDTH'(bound);
      item.scaled = product[PRODUCT_WIDTH-1:WORD_WIDTH];
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_draws.delete();
         seed_table(DEFAULT_SEED);
      end else begin
         // Compare each response transaction with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_draws.size() == 0) begin
               $display("%0t: response with no request outstanding, word %h scaled %h",
                        $time, rsp_word, rsp_scaled);
               error_count++;
            end else begin
               oldest = expected_draws.pop_front();
               if (oldest.word !== rsp_word) begin
                  $display("%0t: word mismatch, expected %h, actual %h",
                           $time, oldest.word, rsp_word);
                  error_count++;
               end
               if (oldest.scaled !== rsp_scaled) begin
                  $display("%0t: scaled mismatch, expected %h, actual %h",
                           $time, oldest.scaled, rsp_scaled);
                  error_count++;
               end
            end
         end
         // A seed write restarts the sequence
         if (psel && penable && pwrite && pready && paddr == SEED_ADDR)
            seed_table(pwdata);
         if (req_valid && req_ready) begin
            predict_draw(req_range, predicted);
            expected_draws.push_back(predicted);
         end
      end
      draws_pending <= expected_draws.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top of the MT19937 generator testbench: clock, reset, request and seed
// stimulus, response back-pressure and the verdict. Depends on mt_pkg,
// mt_if, the generator RTL and mt_draw_checker.
module tb;
   import mt_pkg::*;

   localparam int LIMIT_CYCLES   = 200000;
   localparam int HOLD_CYCLES    = 120;
   localparam int PHASE_DRAWS    = 135;
   localparam int DRAIN_CYCLES   = 8;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      psel;
   logic                      penable;
   logic                      pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [CSR_DATA_WIDTH-1:0] pwdata;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int sent_count    = 0;
   int hold_at       = -1;
   int hold_left     = 0;
   bit hold_done     = 1'b0;
   int cycle_count   = 0;
   int draws_pending;
   int error_count;

   mt_req_if req_chan ();
   mt_rsp_if rsp_chan ();

   mt19937_random_generator dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   mt_draw_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_range     (req_chan.range),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_word      (rsp_chan.word),
      .rsp_scaled    (rsp_chan.scaled),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .draws_pending (draws_pending),
      .error_count   (error_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Response back-pressure, with one long hold-off to fill the block
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && sent_count == hold_at) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one request transaction and hold it until accepted
   task automatic send_draw(input logic [RANGE_WIDTH-1:0] bound);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.range <= bound;
      do @(posedge clock); while (!req_chan.ready);
      sent_count <= sent_count + 1;
   endtask

   // Drop valid and wait until every predicted draw has come back
   task automatic wait_drained;
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (draws_pending != 0 || !req_chan.ready);
   endtask

   // Setup and access cycle of a seed write
   task automatic write_seed(input word_type value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SEED_ADDR;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Mix of zero, full-scale, small, single-bit and fully random bounds
   function automatic logic [RANGE_WIDTH-1:0] random_bound;
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return RANGE_WIDTH'($urandom_range(15));
         3:       return RANGE_WIDTH'(1) << $urandom_range(RANGE_WIDTH - 1);
         default: return RANGE_WIDTH'($urandom);
      endcase
   endfunction

   task automatic run_random(input int count);
      for (int n = 0; n < count; n++)
         send_draw(random_bound());
   endtask

   initial begin
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_chan.valid = 1'b0;
      req_chan.range = '0;
      rsp_chan.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Default seed after reset: zero, extreme and alternating bounds
      send_draw('0);
      send_draw(31'd1);
      send_draw(31'h7fff_ffff);
      send_draw(31'h4000_0000);
      send_draw(31'h2aaa_aaaa);
      send_draw(31'h5555_5555);
      send_draw(31'd2);
      send_draw(31'h7fff_fffe);

      // Seed extremes, then the default seed again to restart as from reset
      wait_drained();
      write_seed('0);
      send_draw(31'h7fff_ffff);
      send_draw('0);
      send_draw(31'd1);
      wait_drained();
      write_seed('1);
      send_draw(31'h7fff_ffff);
      send_draw(31'h0000_ffff);
      send_draw('0);
      wait_drained();
      write_seed(DEFAULT_SEED);
      send_draw(31'h7fff_ffff);
      send_draw(31'h1234_5678);

      // Sender rarely idle, receiver mostly stalled
      wait_drained();
      write_seed($urandom);
      send_idle_pct = 7;
      recv_idle_pct = 75;
      run_random(PHASE_DRAWS);

      // Sender mostly idle, receiver rarely stalled
      wait_drained();
      write_seed($urandom);
      send_idle_pct = 75;
      recv_idle_pct = 7;
      run_random(PHASE_DRAWS);

      // Full rate, with a long receiver hold-off and a full drain midway
      wait_drained();
      write_seed($urandom);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_at = sent_count + 30;
      run_random(70);
      wait_drained();
      run_random(PHASE_DRAWS - 70);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
